FILE: src/nle_pkg.sv
// Shared types and constants for the nearest landmark encoder.
`timescale 1ns / 1ps

package nle_pkg;

  localparam int COORD_W = 16;
  localparam int SLOT_W  = 7;
  localparam int CNT_W   = 8;
  localparam int SQ_W    = 33;  // square of a 17-bit difference, at most 2^32
  localparam int DIST_W  = 34;  // sum of two squares

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Landmark write broadcast to every cell.
  typedef struct packed {
    logic                      en;
    logic [SLOT_W-1:0]         slot;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } wr_t;

  // Query beat handed from cell to cell with the best match found so far.
  typedef struct packed {
    logic                      valid;
    logic signed [COORD_W-1:0] qx;
    logic signed [COORD_W-1:0] qy;
    logic [DIST_W-1:0]         sq_sum;
    logic signed [COORD_W-1:0] lx;
    logic signed [COORD_W-1:0] ly;
  } beat_t;

endpackage

FILE: src/nearest_landmark_encoder.sv
// Top level of the nearest landmark encoder: cell chain, handshakes and result register.
`timescale 1ns / 1ps

// Brute-force 2-D nearest-landmark search. A write beat (operation 0) stores
// coord_x/coord_y into landmark slot landmark_slot and returns nothing; slots
// at or above MAX_POINTS are dropped. A query beat (operation 1) walks a row of
// MAX_POINTS cells, through the stage A and stage B registers of each: a cell squares
// the offsets to its landmark, then adds and compares against the best match
// carried along, keeping the lower index on ties. Cells at or above point_count
// pass the query through untouched (a count of zero searches landmark 0 only).
// The edge that accepts a query loads the first cell, and out_valid rises once
// the query has left the last cell, whatever point_count holds. One query is in
// flight at a time: in_ready stays low from the accepting edge until out_valid
// rises, so a new query is not taken before the last one has left the chain. A
// finished query that meets a result still held by a low out_ready stalls the
// chain, and in_ready stays low until that result leaves. Writes are taken
// whenever no query is in flight, also while a finished result still waits on
// out_ready. Offsets are query minus landmark, saturated to 16 bits. Reading a
// slot never written since reset gives undefined results. point_count resets
// to 1; the user must write it through cfg_wr_en/cfg_wr_data only while the
// block is idle, and the block itself does not enforce this.
module nearest_landmark_encoder #(
  parameter int MAX_POINTS = 128
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [nle_pkg::CNT_W-1:0]          cfg_wr_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_operation,
  input  logic [nle_pkg::SLOT_W-1:0]         in_landmark_slot,
  input  logic signed [nle_pkg::COORD_W-1:0] in_coord_x,
  input  logic signed [nle_pkg::COORD_W-1:0] in_coord_y,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [nle_pkg::SLOT_W-1:0]         out_nearest_index,
  output logic signed [nle_pkg::COORD_W-1:0] out_offset_x,
  output logic signed [nle_pkg::COORD_W-1:0] out_offset_y
);

  import nle_pkg::*;

  localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CMP_W = 11;  // holds any cell number and any count

  logic [CNT_W-1:0] point_count_r;
  logic             busy_r;
  logic             out_valid_r;
  logic [SLOT_W-1:0]         idx_out_r;
  logic signed [COORD_W-1:0] ofs_x_r, ofs_y_r;

  beat_t            chain  [0:MAX_POINTS];
  logic [IDX_W-1:0] chain_idx [0:MAX_POINTS];

  wr_t   wr;
  logic  in_beat;
  logic  adv;
  logic  last_done;
  logic signed [COORD_W:0]   diff_x, diff_y;
  logic [IDX_W+SLOT_W-1:0]   idx_wide;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      point_count_r <= CNT_W'(1);
    end else if (cfg_wr_en) begin
      point_count_r <= cfg_wr_data;
    end
  end

  assign in_ready = !busy_r;
  assign in_beat  = in_valid && in_ready;

  assign wr.en   = in_beat && (in_operation == OP_WRITE);
  assign wr.slot = in_landmark_slot;
  assign wr.x    = in_coord_x;
  assign wr.y    = in_coord_y;

  // Feed a query into the head of the chain
  assign chain[0].valid  = in_beat && (in_operation == OP_QUERY);
  assign chain[0].qx     = in_coord_x;
  assign chain[0].qy     = in_coord_y;
  assign chain[0].sq_sum = '0;
  assign chain[0].lx     = '0;
  assign chain[0].ly     = '0;
  assign chain_idx[0]    = '0;

  // Hold the whole chain while a finished query cannot reach the result register
  assign adv       = !(chain[MAX_POINTS].valid && out_valid_r && !out_ready);
  assign last_done = chain[MAX_POINTS].valid && adv;

  for (genvar j = 0; j < MAX_POINTS; j++) begin : g_cell
    nle_cell #(
      .J     (j),
      .IDX_W (IDX_W)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .active   (CMP_W'(j) < {{(CMP_W-CNT_W){1'b0}}, point_count_r}),
      .wr       (wr),
      .prev     (chain[j]),
      .prev_idx (chain_idx[j]),
      .nxt      (chain[j+1]),
      .nxt_idx  (chain_idx[j+1])
    );
  end

  // One query in flight at a time
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (chain[0].valid) begin
      busy_r <= 1'b1;
    end else if (last_done) begin
      busy_r <= 1'b0;
    end
  end

  // Result: offsets saturate where the 17-bit difference leaves the 16-bit range
  assign diff_x   = {chain[MAX_POINTS].qx[COORD_W-1], chain[MAX_POINTS].qx}
                  - {chain[MAX_POINTS].lx[COORD_W-1], chain[MAX_POINTS].lx};
  assign diff_y   = {chain[MAX_POINTS].qy[COORD_W-1], chain[MAX_POINTS].qy}
                  - {chain[MAX_POINTS].ly[COORD_W-1], chain[MAX_POINTS].ly};
  assign idx_wide = {{SLOT_W{1'b0}}, chain_idx[MAX_POINTS]};

  function automatic logic signed [COORD_W-1:0] sat16(input logic signed [COORD_W:0] v);
    logic signed [COORD_W-1:0] r;
    if (v[COORD_W] != v[COORD_W-1]) begin
      r = v[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
    end else begin
      r = v[COORD_W-1:0];
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (last_done) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (last_done) begin
      idx_out_r <= idx_wide[SLOT_W-1:0];
      ofs_x_r   <= sat16(diff_x);
      ofs_y_r   <= sat16(diff_y);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_nearest_index = idx_out_r;
  assign out_offset_x      = ofs_x_r;
  assign out_offset_y      = ofs_y_r;

endmodule

FILE: src/nle_cell.sv
// One landmark cell: holds a landmark and folds it into the passing query's best match.
`timescale 1ns / 1ps

module nle_cell #(
  parameter int J     = 0,
  parameter int IDX_W = 7
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  logic               active,
  input  nle_pkg::wr_t       wr,
  input  nle_pkg::beat_t     prev,
  input  logic [IDX_W-1:0]   prev_idx,
  output nle_pkg::beat_t     nxt,
  output logic [IDX_W-1:0]   nxt_idx
);

  import nle_pkg::*;

  localparam int SEL_W = 10;  // wide enough for any cell number

  logic signed [COORD_W-1:0] lx_r, ly_r;

  beat_t             a_r;
  logic [IDX_W-1:0]  a_idx_r;
  logic [SQ_W-1:0]   sqx_r, sqy_r;

  beat_t             b_r;
  logic [IDX_W-1:0]  b_idx_r;

  logic signed [COORD_W:0]     dx, dy;
  logic signed [2*COORD_W+1:0] px, py;
  logic [DIST_W-1:0]           d;
  logic                        take;

  // Landmark storage
  always_ff @(posedge clk) begin
    if (wr.en && ({{(SEL_W-SLOT_W){1'b0}}, wr.slot} == SEL_W'(J))) begin
      lx_r <= wr.x;
      ly_r <= wr.y;
    end
  end

  // Stage A: squares of the differences
  assign dx = {lx_r[COORD_W-1], lx_r} - {prev.qx[COORD_W-1], prev.qx};
  assign dy = {ly_r[COORD_W-1], ly_r} - {prev.qy[COORD_W-1], prev.qy};
  assign px = dx * dx;
  assign py = dy * dy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r.valid <= 1'b0;
    end else if (adv) begin
      a_r.valid <= prev.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_r.qx     <= prev.qx;
      a_r.qy     <= prev.qy;
      a_r.sq_sum <= prev.sq_sum;
      a_r.lx     <= prev.lx;
      a_r.ly     <= prev.ly;
      a_idx_r    <= prev_idx;
      sqx_r      <= px[SQ_W-1:0];
      sqy_r      <= py[SQ_W-1:0];
    end
  end

  // Stage B: distance and compare; the first cell always takes the lead
  assign d    = {1'b0, sqx_r} + {1'b0, sqy_r};
  assign take = (J == 0) || (active && (d < a_r.sq_sum));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_r.valid <= 1'b0;
    end else if (adv) begin
      b_r.valid <= a_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_r.qx <= a_r.qx;
      b_r.qy <= a_r.qy;
      if (take) begin
        b_r.sq_sum <= d;
        b_r.lx     <= lx_r;
        b_r.ly     <= ly_r;
        b_idx_r    <= IDX_W'(J);
      end else begin
        b_r.sq_sum <= a_r.sq_sum;
        b_r.lx     <= a_r.lx;
        b_r.ly     <= a_r.ly;
        b_idx_r    <= a_idx_r;
      end
    end
  end

  assign nxt     = b_r;
  assign nxt_idx = b_idx_r;

endmodule
